[design/ima_adpcm_nibble_decoder_top_macros.svh]
`ifndef IMA_ADPCM_NIBBLE_DECODER_TOP_MACROS_SVH
`define IMA_ADPCM_NIBBLE_DECODER_TOP_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define IMADEC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define IMADEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMADEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/imadec_pkg.sv]
`timescale 1ns / 1ps

package imadec_pkg;

    localparam int CODE_W     = 4;
    localparam int DELTA_W    = 3;
    localparam int PCM_W      = 16;
    localparam int IDX_W      = 7;
    localparam int STEP_W     = 15;
    localparam int MAG_W      = 16;
    localparam int MOVE_W     = 5;
    localparam int MODE_W     = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int IDX_MAX = 88;

    localparam logic signed [PCM_W-1:0] PCM_MAX_V = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN_V = 16'sh8000;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_EXACT0  = 2'd0;
    localparam t_mode MODE_EXACT1  = 2'd1;
    localparam t_mode MODE_QUARTER = 2'd2;
    localparam t_mode MODE_EIGHTH  = 2'd3;

    localparam logic REG_DECODE_MODE = 1'b0;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              start;
    } t_item;

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [MOVE_W-1:0] index_move(input logic [DELTA_W-1:0] delta);
        logic signed [MOVE_W-1:0] m;
        unique case (delta)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

[design/imadec_apb.sv]
`timescale 1ns / 1ps

module imadec_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imadec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [imadec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [imadec_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output imadec_pkg::t_mode                 o_mode
);
    import imadec_pkg::*;

    t_mode r_mode;
    logic  w_sel_mode;

    // Register index is the word address; low byte-lane bits are ignored.
    assign w_sel_mode = (paddr[APB_ADDR_W-1] == REG_DECODE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EXACT0;
        end else if (psel && penable && pwrite && w_sel_mode) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = w_sel_mode ? {{(APB_DATA_W-MODE_W){1'b0}}, r_mode} : '0;
    assign pready = 1'b1;
    assign o_mode = r_mode;

endmodule

[design/imadec_core.sv]
`timescale 1ns / 1ps
`include "ima_adpcm_nibble_decoder_top_macros.svh"

module imadec_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  imadec_pkg::t_item                   i_item,
    input  imadec_pkg::t_mode                   i_mode,
    output logic signed [imadec_pkg::PCM_W-1:0] o_pcm_sample,
    output logic [imadec_pkg::IDX_W-1:0]        o_step_index
);
    import imadec_pkg::*;

    localparam int SUM_W   = PCM_W + 2;
    localparam int PROD2_W = DELTA_W + STEP_W;
    localparam int PROD3_W = DELTA_W + 1 + STEP_W;

    logic signed [PCM_W-1:0] r_pred;
    logic signed [PCM_W-1:0] n_pred;
    logic [IDX_W-1:0]        r_pos;
    logic [IDX_W-1:0]        n_pos;

    logic signed [PCM_W-1:0] w_base_pred;
    logic [IDX_W-1:0]        w_base_pos;
    logic [IDX_W-1:0]        w_pos;
    logic [STEP_W-1:0]       w_step;
    logic [DELTA_W-1:0]      w_delta;
    logic [PROD2_W-1:0]      w_prod2;
    logic [PROD3_W-1:0]      w_prod3;
    logic [MAG_W-1:0]        w_mag;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [IDX_W:0]   w_idx;

    always_comb begin
        // A start item decodes from cleared state.
        w_base_pred = i_item.start ? '0 : r_pred;
        w_base_pos  = i_item.start ? '0 : r_pos;
        w_pos       = (w_base_pos > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : w_base_pos;
        w_step      = step_size(w_pos);
        w_delta     = i_item.code[DELTA_W-1:0];
        w_prod2     = PROD2_W'(w_delta) * PROD2_W'(w_step);
        w_prod3     = PROD3_W'({w_delta, 1'b1}) * PROD3_W'(w_step);

        case (i_mode) inside
            MODE_QUARTER: w_mag = MAG_W'(w_prod2 >> 2) + MAG_W'(w_step >> 3);
            MODE_EIGHTH:  w_mag = MAG_W'(w_prod3 >> 3);
            MODE_EXACT0, MODE_EXACT1: begin
                // Truncate each shifted step on its own, as the classic decoder does.
                w_mag = (w_delta[2] ? MAG_W'(w_step)      : '0)
                      + (w_delta[1] ? MAG_W'(w_step >> 1) : '0)
                      + (w_delta[0] ? MAG_W'(w_step >> 2) : '0)
                      + MAG_W'(w_step >> 3);
            end
            default: w_mag = '0;
        endcase

        if (i_item.code[CODE_W-1]) begin
            w_sum = SUM_W'(w_base_pred) - $signed({2'b00, w_mag});
        end else begin
            w_sum = SUM_W'(w_base_pred) + $signed({2'b00, w_mag});
        end

        // Saturate when the top three bits disagree.
        if (w_sum[SUM_W-1:PCM_W-1] == 3'b000 || w_sum[SUM_W-1:PCM_W-1] == 3'b111) begin
            n_pred = w_sum[PCM_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n_pred = PCM_MIN_V;
        end else begin
            n_pred = PCM_MAX_V;
        end

        w_idx = $signed({1'b0, w_pos}) + (IDX_W+1)'(index_move(w_delta));
        if (w_idx[IDX_W]) begin
            n_pos = '0;
        end else if (w_idx[IDX_W-1:0] > IDX_W'(IDX_MAX)) begin
            n_pos = IDX_W'(IDX_MAX);
        end else begin
            n_pos = w_idx[IDX_W-1:0];
        end
    end

    // State doubles as the result register: it only advances when the result is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred <= '0;
            r_pos  <= '0;
        end else if (i_fire) begin
            r_pred <= n_pred;
            r_pos  <= n_pos;
        end
    end

    assign o_pcm_sample = r_pred;
    assign o_step_index = r_pos;

    `IMADEC_ASSERT_ALWAYS(a_pos_in_range, r_pos <= IDX_W'(IDX_MAX), "step index above table end")
    `IMADEC_ASSERT_NEXT(a_pos_sample_no_wrap, i_fire && !i_item.start && !i_item.code[CODE_W-1], $signed(r_pred) >= $signed($past(r_pred)), "positive code lowered sample")
    `IMADEC_ASSERT_NEXT(a_start_zero_code, i_fire && i_item.start && i_item.code == '0, r_pred == '0 && r_pos == '0, "start with zero code not from cleared state")

endmodule

[design/ima_adpcm_nibble_decoder_top.sv]
`timescale 1ns / 1ps
`include "ima_adpcm_nibble_decoder_top_macros.svh"

// IMA ADPCM decoder for a continuous nibble stream. Each accepted item carries a
// 4-bit code (bit 3 sign, bits 2..0 magnitude) and a start flag that clears the
// predictor and step index before that code is decoded. Each item yields one
// result: the saturated 16-bit sample and the step index after adjustment. One
// item is accepted per clock unless the output stalls; a result is registered
// as its item leaves the input register. The step table read, the difference
// multiply or shift-add and the sample clamp sit between the input register and
// the predictor register, also the result register. Register 0 (byte address 0)
// selects the difference mode: 0 or 1 exact shift-add, 2 quarter-step, 3
// eighth-step approximation; write it only while the block is idle.
module ima_adpcm_nibble_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [imadec_pkg::CODE_W-1:0]       i_code,
    input  logic                                i_start_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [imadec_pkg::PCM_W-1:0] o_pcm_sample,
    output logic [imadec_pkg::IDX_W-1:0]        o_step_index,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [imadec_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [imadec_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [imadec_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);
    import imadec_pkg::*;

    logic  r_in_valid;
    t_item r_item;
    logic  r_out_valid;
    logic  w_fire;
    t_mode w_mode;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.code  <= i_code;
            r_item.start <= i_start_req;
        end
    end

    imadec_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    imadec_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (r_item),
        .i_mode       (w_mode),
        .o_pcm_sample (o_pcm_sample),
        .o_step_index (o_step_index)
    );

    assign o_out_valid = r_out_valid;

    `IMADEC_ASSERT_IMP(a_stall_cause, !o_in_ready,
        r_in_valid && r_out_valid && !i_out_ready, "input stalled without a blocked result")
    `IMADEC_ASSERT_NEXT(a_empty_out_fills, r_in_valid && !r_out_valid,
        r_out_valid, "pending item not moved to empty result")
    `IMADEC_ASSERT_NEXT(a_mode_write,
        psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_DECODE_MODE),
        w_mode == $past(pwdata[MODE_W-1:0]), "mode write lost")

endmodule
